### src/mbc_pkg.sv
// ----------------------------------------------------------------------------
// Maze carver package
// Payload types, codes and controller/datapath interface structs shared by
// the maze carver modules.
// ----------------------------------------------------------------------------
package mbc_pkg;

	// Default geometry and stack size
	localparam int GridColsDef   = 80;
	localparam int GridRowsDef   = 21;
	localparam int StackDepthDef = 420;

	// Width of internal coordinate arithmetic; wide enough that a step
	// below zero wraps far outside any legal grid.
	localparam int CoordW = 9;

	// Distance of the carving border from the grid edge
	localparam int EdgeMargin = 3;

	typedef enum logic [1:0] {
		CMD_CLEAR = 2'd0,
		CMD_START = 2'd1,
		CMD_STEP  = 2'd2,
		CMD_READ  = 2'd3
	} cmd_code_t;

	typedef enum logic [2:0] {
		ST_ACK         = 3'd0,
		ST_ADVANCED    = 3'd1,
		ST_BACKTRACKED = 3'd2,
		ST_FINISHED    = 3'd3,
		ST_OVERFLOW    = 3'd4
	} status_t;

	// Which square the grid memory port addresses
	typedef enum logic [2:0] {
		A_TOP  = 3'd0,
		A_UP   = 3'd1,
		A_DOWN = 3'd2,
		A_MID  = 3'd3,
		A_FAR  = 3'd4,
		A_POS  = 3'd5
	} addr_sel_t;

	typedef struct packed {
		logic [1:0] command;
		logic [6:0] pos_x;
		logic [4:0] pos_y;
		logic [7:0] rand_value;
	} cmd_payload_t;

	typedef struct packed {
		logic [2:0] status;
		logic [6:0] top_x;
		logic [4:0] top_y;
		logic       square_open;
		logic [8:0] stack_depth;
	} rsp_payload_t;

	// Controller to datapath
	typedef struct packed {
		logic      cap;
		logic      grid_clear;
		logic      row_rd;
		logic      row_wr;
		addr_sel_t addr_sel;
		logic      chk_horiz;
		logic      chk_up;
		logic      chk_down;
		logic      choose;
		logic      stk_start;
		logic      stk_push;
		logic      stk_pop;
		logic      top_from_stk;
		logic      sq_load;
		logic      rsp_load;
		status_t   rsp_status;
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic sp_zero;
		logic sp_one;
		logic sp_full;
		logic any_cand;
	} dp_stat_t;

endpackage

### src/mbc_stream_if.sv
// ----------------------------------------------------------------------------
// Maze carver stream interface
// Valid/ready channel carrying one payload item per transfer.
// ----------------------------------------------------------------------------
interface mbc_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

### src/mbc_ctrl.sv
// ----------------------------------------------------------------------------
// Maze carver controller
// Sequences each command over the single-port grid and stack memories.
// ----------------------------------------------------------------------------
module mbc_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic [1:0]         in_command,
	output logic               in_ready,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output mbc_pkg::dp_cmd_t   ctl,
	input  mbc_pkg::dp_stat_t  stat
);

	typedef enum logic [16:0] {
		S_IDLE    = 17'h00001,
		S_CLEAR   = 17'h00002,
		S_START   = 17'h00004,
		S_SQ_RD   = 17'h00008,
		S_SQ_CHK  = 17'h00010,
		S_TOP_RD  = 17'h00020,
		S_TOP_WR  = 17'h00040,
		S_UP_RD   = 17'h00080,
		S_UP_CHK  = 17'h00100,
		S_DN_CHK  = 17'h00200,
		S_DECIDE  = 17'h00400,
		S_POP_LD  = 17'h00800,
		S_MID_RD  = 17'h01000,
		S_MID_WR  = 17'h02000,
		S_FAR_RD  = 17'h04000,
		S_FAR_WR  = 17'h08000,
		S_RESP    = 17'h10000
	} state_t;

	state_t            state_q, state_d;
	mbc_pkg::status_t  status_q, status_d;
	logic              rsp_valid_q;
	logic              slot_free;

	assign in_ready  = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign slot_free = !rsp_valid_q || rsp_ready;

	always_comb begin
		state_d  = state_q;
		status_d = status_q;
		ctl      = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					ctl.cap  = 1'b1;
					status_d = mbc_pkg::ST_ACK;
					case (mbc_pkg::cmd_code_t'(in_command))
						mbc_pkg::CMD_CLEAR: state_d = S_CLEAR;
						mbc_pkg::CMD_START: state_d = S_START;
						mbc_pkg::CMD_STEP:  state_d = S_TOP_RD;
						mbc_pkg::CMD_READ:  state_d = S_SQ_RD;
						default:            state_d = S_CLEAR;
					endcase
				end
			end
			S_CLEAR: begin
				ctl.grid_clear = 1'b1;
				state_d        = S_RESP;
			end
			S_START: begin
				ctl.stk_start = 1'b1;
				state_d       = S_RESP;
			end
			S_SQ_RD: begin
				ctl.row_rd   = 1'b1;
				ctl.addr_sel = mbc_pkg::A_POS;
				state_d      = S_SQ_CHK;
			end
			S_SQ_CHK: begin
				ctl.sq_load  = 1'b1;
				ctl.addr_sel = mbc_pkg::A_POS;
				state_d      = S_RESP;
			end
			S_TOP_RD: begin
				if (stat.sp_zero) begin
					status_d = mbc_pkg::ST_FINISHED;
					state_d  = S_RESP;
				end else begin
					ctl.row_rd   = 1'b1;
					ctl.addr_sel = mbc_pkg::A_TOP;
					state_d      = S_TOP_WR;
				end
			end
			S_TOP_WR: begin
				ctl.row_wr    = 1'b1;
				ctl.addr_sel  = mbc_pkg::A_TOP;
				ctl.chk_horiz = 1'b1;
				state_d       = S_UP_RD;
			end
			S_UP_RD: begin
				ctl.row_rd   = 1'b1;
				ctl.addr_sel = mbc_pkg::A_UP;
				state_d      = S_UP_CHK;
			end
			S_UP_CHK: begin
				ctl.chk_up   = 1'b1;
				ctl.row_rd   = 1'b1;
				ctl.addr_sel = mbc_pkg::A_DOWN;
				state_d      = S_DN_CHK;
			end
			S_DN_CHK: begin
				ctl.chk_down = 1'b1;
				state_d      = S_DECIDE;
			end
			S_DECIDE: begin
				if (!stat.any_cand) begin
					ctl.stk_pop = 1'b1;
					if (stat.sp_one) begin
						status_d = mbc_pkg::ST_FINISHED;
						state_d  = S_RESP;
					end else begin
						status_d = mbc_pkg::ST_BACKTRACKED;
						state_d  = S_POP_LD;
					end
				end else if (stat.sp_full) begin
					status_d = mbc_pkg::ST_OVERFLOW;
					state_d  = S_RESP;
				end else begin
					ctl.choose = 1'b1;
					status_d   = mbc_pkg::ST_ADVANCED;
					state_d    = S_MID_RD;
				end
			end
			S_POP_LD: begin
				ctl.top_from_stk = 1'b1;
				state_d          = S_RESP;
			end
			S_MID_RD: begin
				ctl.row_rd   = 1'b1;
				ctl.addr_sel = mbc_pkg::A_MID;
				state_d      = S_MID_WR;
			end
			S_MID_WR: begin
				ctl.row_wr   = 1'b1;
				ctl.addr_sel = mbc_pkg::A_MID;
				state_d      = S_FAR_RD;
			end
			S_FAR_RD: begin
				ctl.row_rd   = 1'b1;
				ctl.addr_sel = mbc_pkg::A_FAR;
				state_d      = S_FAR_WR;
			end
			S_FAR_WR: begin
				ctl.row_wr   = 1'b1;
				ctl.addr_sel = mbc_pkg::A_FAR;
				ctl.stk_push = 1'b1;
				state_d      = S_RESP;
			end
			S_RESP: begin
				// hold until the output register is free
				if (slot_free) begin
					ctl.rsp_load   = 1'b1;
					ctl.rsp_status = status_q;
					state_d        = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			status_q    <= mbc_pkg::ST_ACK;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			status_q <= status_d;
			if (ctl.rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

### src/mbc_datapath.sv
// ----------------------------------------------------------------------------
// Maze carver datapath
// Grid row memory, walk stack memory, neighbour checks and direction choice.
// ----------------------------------------------------------------------------
module mbc_datapath #(
	parameter int GRID_COLS   = mbc_pkg::GridColsDef,
	parameter int GRID_ROWS   = mbc_pkg::GridRowsDef,
	parameter int STACK_DEPTH = mbc_pkg::StackDepthDef
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  mbc_pkg::cmd_payload_t in_data,
	input  mbc_pkg::dp_cmd_t      ctl,
	output mbc_pkg::dp_stat_t     stat,
	output mbc_pkg::rsp_payload_t rsp_data
);

	localparam int CW     = mbc_pkg::CoordW;
	localparam int ROW_AW = $clog2(GRID_ROWS);
	localparam int COL_AW = $clog2(GRID_COLS);
	localparam int STK_AW = $clog2(STACK_DEPTH);
	localparam int SP_W   = $clog2(STACK_DEPTH + 1);

	localparam logic [CW-1:0] LoBound  = CW'(mbc_pkg::EdgeMargin);
	localparam logic [CW-1:0] HiBoundX = CW'(GRID_COLS - mbc_pkg::EdgeMargin);
	localparam logic [CW-1:0] HiBoundY = CW'(GRID_ROWS - mbc_pkg::EdgeMargin);

	typedef enum logic [1:0] {
		DIR_UP    = 2'd0,
		DIR_RIGHT = 2'd1,
		DIR_DOWN  = 2'd2,
		DIR_LEFT  = 2'd3
	} dir_t;

	typedef struct packed {
		logic [4:0] y;
		logic [6:0] x;
	} stk_entry_t;

	// Sum of base-4 digits, reduced mod 3 per digit, then index by count
	function automatic logic [1:0] rand_mod(input logic [7:0] r, input logic [2:0] n);
		logic [2:0] acc;
		logic [1:0] res;
		acc = '0;
		for (int i = 0; i < 4; i++) begin
			acc = acc + 3'(r[2*i +: 2]);
			if (acc >= 3'd3) begin
				acc = acc - 3'd3;
			end
		end
		case (n)
			3'd1:    res = 2'd0;
			3'd2:    res = {1'b0, r[0]};
			3'd3:    res = acc[1:0];
			default: res = r[1:0];
		endcase
		return res;
	endfunction

	// Pick the k-th set flag in direction order
	function automatic logic [1:0] pick_dir(input logic [3:0] c, input logic [1:0] k);
		logic [2:0] seen;
		logic [1:0] sel;
		seen = '0;
		sel  = '0;
		for (int d = 0; d < 4; d++) begin
			if (c[d]) begin
				if (seen == 3'(k)) begin
					sel = 2'(d);
				end
				seen = seen + 3'd1;
			end
		end
		return sel;
	endfunction

	function automatic logic far_ok(input logic [CW-1:0] fx, input logic [CW-1:0] fy);
		return (fx >= LoBound) && (fx <= HiBoundX) && (fy >= LoBound) && (fy <= HiBoundY);
	endfunction

	// Captured item
	logic [6:0]            px_q;
	logic [4:0]            py_q;
	logic [7:0]            rnd_q;

	// Walk state
	logic [6:0]            top_x_q;
	logic [4:0]            top_y_q;
	logic [SP_W-1:0]       sp_q;
	logic [3:0]            cand_q;
	dir_t                  dir_q;
	logic                  sq_q;

	// Memories
	logic [GRID_COLS-1:0]  grid_mem [GRID_ROWS];
	logic [GRID_ROWS-1:0]  row_vld_q;
	logic [GRID_COLS-1:0]  row_rd_q;
	logic                  row_hit_q;
	logic [GRID_COLS-1:0]  row_q;
	logic [GRID_COLS-1:0]  wr_row;
	stk_entry_t            stk_mem [STACK_DEPTH];
	stk_entry_t            stk_rd_q;

	// Addressing
	logic [CW-1:0]         tx, ty;
	logic [CW-1:0]         mid_x, mid_y, far_x, far_y;
	logic [CW-1:0]         a_x, a_y;
	logic                  a_row_ok, a_in_grid;
	logic [ROW_AW-1:0]     ra;
	logic [COL_AW-1:0]     ca;
	logic [2:0]            cand_cnt;
	logic [STK_AW-1:0]     sp_wr_idx, sp_rd_idx;

	assign tx = CW'(top_x_q);
	assign ty = CW'(top_y_q);

	always_comb begin
		case (dir_q)
			DIR_UP: begin
				mid_x = tx;                 mid_y = ty - CW'(1);
				far_x = tx;                 far_y = ty - CW'(2);
			end
			DIR_RIGHT: begin
				mid_x = tx + CW'(1);        mid_y = ty;
				far_x = tx + CW'(2);        far_y = ty;
			end
			DIR_DOWN: begin
				mid_x = tx;                 mid_y = ty + CW'(1);
				far_x = tx;                 far_y = ty + CW'(2);
			end
			DIR_LEFT: begin
				mid_x = tx - CW'(1);        mid_y = ty;
				far_x = tx - CW'(2);        far_y = ty;
			end
			default: begin
				mid_x = tx;                 mid_y = ty;
				far_x = tx;                 far_y = ty;
			end
		endcase
	end

	always_comb begin
		case (ctl.addr_sel)
			mbc_pkg::A_TOP:  begin a_x = tx;            a_y = ty;            end
			mbc_pkg::A_UP:   begin a_x = tx;            a_y = ty - CW'(2);   end
			mbc_pkg::A_DOWN: begin a_x = tx;            a_y = ty + CW'(2);   end
			mbc_pkg::A_MID:  begin a_x = mid_x;         a_y = mid_y;         end
			mbc_pkg::A_FAR:  begin a_x = far_x;         a_y = far_y;         end
			mbc_pkg::A_POS:  begin a_x = CW'(px_q);     a_y = CW'(py_q);     end
			default:         begin a_x = tx;            a_y = ty;            end
		endcase
	end

	assign a_row_ok  = (a_y < CW'(GRID_ROWS));
	assign a_in_grid = a_row_ok && (a_x < CW'(GRID_COLS));
	assign ra        = a_y[ROW_AW-1:0];
	assign ca        = a_x[COL_AW-1:0];

	// A row never written since the last clear reads as all closed
	assign row_q = row_hit_q ? row_rd_q : '0;

	always_comb begin
		wr_row     = row_q;
		wr_row[ca] = 1'b1;
	end

	always_ff @(posedge clk) begin
		if (ctl.row_wr && a_in_grid) begin
			grid_mem[ra] <= wr_row;
		end
		if (ctl.row_rd && a_row_ok) begin
			row_rd_q <= grid_mem[ra];
		end
		if (ctl.row_rd) begin
			row_hit_q <= a_row_ok && row_vld_q[ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
		end else if (ctl.grid_clear) begin
			row_vld_q <= '0;
		end else if (ctl.row_wr && a_in_grid) begin
			row_vld_q[ra] <= 1'b1;
		end
	end

	// Walk stack
	assign sp_wr_idx = sp_q[STK_AW-1:0];
	assign sp_rd_idx = STK_AW'(sp_q - SP_W'(2));

	always_ff @(posedge clk) begin
		if (ctl.stk_start) begin
			stk_mem[0] <= '{y: py_q, x: px_q};
		end else if (ctl.stk_push) begin
			stk_mem[sp_wr_idx] <= '{y: far_y[4:0], x: far_x[6:0]};
		end
		if (ctl.stk_pop) begin
			stk_rd_q <= stk_mem[sp_rd_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q <= '0;
		end else if (ctl.stk_start) begin
			sp_q <= SP_W'(1);
		end else if (ctl.stk_push) begin
			sp_q <= sp_q + SP_W'(1);
		end else if (ctl.stk_pop) begin
			sp_q <= sp_q - SP_W'(1);
		end
	end

	// Neighbour checks and choice
	assign cand_cnt = 3'(cand_q[0]) + 3'(cand_q[1]) + 3'(cand_q[2]) + 3'(cand_q[3]);

	always_ff @(posedge clk) begin
		if (ctl.cap) begin
			px_q  <= in_data.pos_x;
			py_q  <= in_data.pos_y;
			rnd_q <= in_data.rand_value;
		end
		if (ctl.cap) begin
			sq_q <= 1'b0;
		end else if (ctl.sq_load) begin
			sq_q <= a_in_grid && row_q[ca];
		end
		if (ctl.chk_horiz) begin
			cand_q[DIR_RIGHT] <= far_ok(tx + CW'(2), ty)
				&& !row_q[COL_AW'(tx + CW'(2))];
			cand_q[DIR_LEFT]  <= far_ok(tx - CW'(2), ty)
				&& !row_q[COL_AW'(tx - CW'(2))];
		end
		if (ctl.chk_up) begin
			cand_q[DIR_UP] <= far_ok(tx, ty - CW'(2)) && !row_q[COL_AW'(tx)];
		end
		if (ctl.chk_down) begin
			cand_q[DIR_DOWN] <= far_ok(tx, ty + CW'(2)) && !row_q[COL_AW'(tx)];
		end
		if (ctl.choose) begin
			dir_q <= dir_t'(pick_dir(cand_q, rand_mod(rnd_q, cand_cnt)));
		end
		if (ctl.stk_start) begin
			top_x_q <= px_q;
			top_y_q <= py_q;
		end else if (ctl.stk_push) begin
			top_x_q <= far_x[6:0];
			top_y_q <= far_y[4:0];
		end else if (ctl.top_from_stk) begin
			top_x_q <= stk_rd_q.x;
			top_y_q <= stk_rd_q.y;
		end
		if (ctl.rsp_load) begin
			rsp_data.status      <= ctl.rsp_status;
			rsp_data.top_x       <= (sp_q == '0) ? 7'd0 : top_x_q;
			rsp_data.top_y       <= (sp_q == '0) ? 5'd0 : top_y_q;
			rsp_data.square_open <= sq_q;
			rsp_data.stack_depth <= 9'(sp_q);
		end
	end

	assign stat.sp_zero  = (sp_q == '0);
	assign stat.sp_one   = (sp_q == SP_W'(1));
	assign stat.sp_full  = (sp_q >= SP_W'(STACK_DEPTH));
	assign stat.any_cand = |cand_q;

endmodule

### src/maze_backtracker_carver.sv
// ----------------------------------------------------------------------------
// Maze backtracker carver
// Carves a maze with a randomised depth-first walk over a grid of squares.
// ----------------------------------------------------------------------------
// Usage:
//   cmd carries one command per transfer: clear the grid, start a walk at a
//   given cell, take one walk step, or read one square. rsp returns exactly
//   one result per command: status, stack top, square bit and stack depth.
//   Items are handled one at a time; cmd.ready is high only while the block
//   is idle, so a new cmd is not taken until the last result is loaded.
//   Each step works over the single-port grid row memory: it reads the top
//   row and the rows two above and below, and carves the middle and far
//   squares by read-modify-write.
//   Reset leaves every square closed (row valid bits cleared at once, so no
//   clearing sweep is needed) and the stack empty.
//   When rsp stalls, the result waits in the output register and the block
//   holds its next result until the register empties.
// ----------------------------------------------------------------------------
module maze_backtracker_carver #(
	parameter int GRID_COLS   = mbc_pkg::GridColsDef,
	parameter int GRID_ROWS   = mbc_pkg::GridRowsDef,
	parameter int STACK_DEPTH = mbc_pkg::StackDepthDef
) (
	input  logic         clk,
	input  logic         arst_n,
	mbc_stream_if.sink   cmd,
	mbc_stream_if.source rsp
);

	mbc_pkg::dp_cmd_t      ctl;
	mbc_pkg::dp_stat_t     stat;
	mbc_pkg::cmd_payload_t cmd_data;
	mbc_pkg::rsp_payload_t rsp_data;
	logic                  in_ready;
	logic                  rsp_valid;

	// Unpack the command payload once so both halves see the same fields
	assign cmd_data  = cmd.data;
	assign cmd.ready = in_ready;
	assign rsp.valid = rsp_valid;
	assign rsp.data  = rsp_data;

	// Sequence each command over the memories
	mbc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (cmd.valid),
		.in_command (cmd_data.command),
		.in_ready   (in_ready),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp.ready),
		.ctl        (ctl),
		.stat       (stat)
	);

	// Hold the grid, the walk stack and the output register
	mbc_datapath #(
		.GRID_COLS   (GRID_COLS),
		.GRID_ROWS   (GRID_ROWS),
		.STACK_DEPTH (STACK_DEPTH)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (cmd_data),
		.ctl      (ctl),
		.stat     (stat),
		.rsp_data (rsp_data)
	);

endmodule

### tb/tb_maze_backtracker_carver.sv
// ----------------------------------------------------------------------------
// Maze backtracker carver testbench
// Drives clear, start, step and read commands into the carver and checks
// every result against a behavioural copy of the walk kept in the bench or
// a typed table line. A directed table comes first. A deep walk follows
// that clears the grid at each dead end until the stack has overflowed six
// times. Random walks, reads and stray commands fill the rest, with random
// idling on both channels and one long result stall.
// ----------------------------------------------------------------------------
module tb_maze_backtracker_carver;
	timeunit 1ns;
	timeprecision 1ps;

	import mbc_pkg::*;

	// Geometry of the grid under test, also passed to the block
	localparam int GRID_COLS   = 80;
	localparam int GRID_ROWS   = 21;
	localparam int STACK_DEPTH = 420;
	// Far squares must lie this far from the edge of the grid
	localparam int BORDER      = 3;

	localparam int TOTAL_ITEMS     = 1700;
	localparam int QUIET_TAIL      = 200;
	localparam int OVERFLOW_TARGET = 6;
	localparam int HOLD_AFTER      = 250;
	localparam int HOLD_CYCLES     = 300;
	localparam int WATCHDOG_CYCLES = 2000;
	localparam int REPORT_LIMIT    = 10;

	// Walk directions, in the order the candidates are gathered
	typedef enum int {
		DIR_UP    = 0,
		DIR_RIGHT = 1,
		DIR_DOWN  = 2,
		DIR_LEFT  = 3
	} dir_t;

	// One line of the directed table; the result fields only count when
	// typed is set, otherwise the carving model supplies the expectation.
	typedef struct {
		cmd_code_t cmd;
		int        x;
		int        y;
		int        rnd;
		bit        typed;
		status_t   st;
		int        tx;
		int        ty;
		int        sq;
		int        depth;
	} directed_row_t;

	logic clk;
	logic arst_n;

	mbc_stream_if #(.payload_t(cmd_payload_t)) cmd_if ();
	mbc_stream_if #(.payload_t(rsp_payload_t)) rsp_if ();

	maze_backtracker_carver #(
		.GRID_COLS  (GRID_COLS),
		.GRID_ROWS  (GRID_ROWS),
		.STACK_DEPTH(STACK_DEPTH)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd_if.sink),
		.rsp   (rsp_if.source)
	);

	// Bench copy of the grid and walk stack
	bit           grid_open [GRID_ROWS][GRID_COLS];
	bit [6:0]     walk_x [STACK_DEPTH];
	bit [4:0]     walk_y [STACK_DEPTH];
	int unsigned  walk_depth = 0;

	// Results still owed by the block, oldest first
	rsp_payload_t expected_results [$];

	int unsigned items_sent = 0;
	int unsigned results_seen = 0;
	int unsigned fault_count = 0;
	int unsigned idle_cycles = 0;
	bit          idle_on = 1'b1;
	bit          hold_done = 1'b0;

	// Directed table: reset state, grid corners, cells outside the grid,
	// an even start cell with no way out, clear with an empty stack, and a
	// short walk whose outcome is left to the model.
	directed_row_t directed_rows [25] = '{
		'{CMD_READ,   0,  0,   0, 1'b1, ST_ACK,      0,  0, 0, 0},
		'{CMD_STEP,   0,  0,   0, 1'b1, ST_FINISHED, 0,  0, 0, 0},
		'{CMD_READ, 127, 31,   0, 1'b1, ST_ACK,      0,  0, 0, 0},
		'{CMD_START, 79, 20,   0, 1'b1, ST_ACK,     79, 20, 0, 1},
		'{CMD_STEP,   0,  0,   0, 1'b1, ST_FINISHED, 0,  0, 0, 0},
		'{CMD_READ,  79, 20,   0, 1'b1, ST_ACK,      0,  0, 1, 0},
		'{CMD_START,127, 31, 255, 1'b1, ST_ACK,    127, 31, 0, 1},
		'{CMD_STEP, 127, 31, 255, 1'b1, ST_FINISHED, 0,  0, 0, 0},
		'{CMD_READ,  79,  0,   0, 1'b1, ST_ACK,      0,  0, 0, 0},
		'{CMD_START,  2,  2,   0, 1'b1, ST_ACK,      2,  2, 0, 1},
		'{CMD_STEP,   0,  0,   7, 1'b1, ST_FINISHED, 0,  0, 0, 0},
		'{CMD_READ,   2,  2,   0, 1'b1, ST_ACK,      0,  0, 1, 0},
		'{CMD_CLEAR,  0,  0,   0, 1'b1, ST_ACK,      0,  0, 0, 0},
		'{CMD_READ,  79, 20,   0, 1'b1, ST_ACK,      0,  0, 0, 0},
		'{CMD_START,  3,  3,   0, 1'b1, ST_ACK,      3,  3, 0, 1},
		'{CMD_STEP,   0,  0,   0, 1'b0, ST_ACK,      0,  0, 0, 0},
		'{CMD_STEP,   0,  0, 255, 1'b0, ST_ACK,      0,  0, 0, 0},
		'{CMD_STEP,   0,  0, 128, 1'b0, ST_ACK,      0,  0, 0, 0},
		'{CMD_READ,   4,  3,   0, 1'b0, ST_ACK,      0,  0, 0, 0},
		'{CMD_CLEAR, 127, 31, 255, 1'b0, ST_ACK,     0,  0, 0, 0},
		'{CMD_STEP,   0,  0,   1, 1'b0, ST_ACK,      0,  0, 0, 0},
		'{CMD_START, 77, 17,   0, 1'b1, ST_ACK,     77, 17, 0, 1},
		'{CMD_STEP,   0,  0,   3, 1'b0, ST_ACK,      0,  0, 0, 0},
		'{CMD_READ,   0, 20,   0, 1'b0, ST_ACK,      0,  0, 0, 0},
		'{CMD_STEP,   0,  0,   2, 1'b0, ST_ACK,      0,  0, 0, 0}
	};

	// ------------------------------------------------------------------
	// Clock and reset
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
	end

	// ------------------------------------------------------------------
	// Carving model
	// ------------------------------------------------------------------
	function automatic int dir_dx(dir_t d);
		if (d == DIR_RIGHT) begin
			return 1;
		end else if (d == DIR_LEFT) begin
			return -1;
		end
		return 0;
	endfunction

	function automatic int dir_dy(dir_t d);
		if (d == DIR_DOWN) begin
			return 1;
		end else if (d == DIR_UP) begin
			return -1;
		end
		return 0;
	endfunction

	// Squares off the grid read as closed and ignore carving
	function automatic bit square_open_at(int x, int y);
		if (x < 0 || y < 0 || x >= GRID_COLS || y >= GRID_ROWS) begin
			return 1'b0;
		end
		return grid_open[y][x];
	endfunction

	function automatic void carve_square(int x, int y);
		if (x >= 0 && y >= 0 && x < GRID_COLS && y < GRID_ROWS) begin
			grid_open[y][x] = 1'b1;
		end
	endfunction

	// Gather the directions whose far square is inside the border and still
	// closed, in direction order; return how many there are.
	function automatic int free_directions(int x, int y, output dir_t dirs [4]);
		int n;
		int fx;
		int fy;
		n = 0;
		for (int d = 0; d < 4; d++) begin
			dirs[d] = DIR_UP;
		end
		for (int d = 0; d < 4; d++) begin
			fx = x + 2 * dir_dx(dir_t'(d));
			fy = y + 2 * dir_dy(dir_t'(d));
			if (fx >= BORDER && fy >= BORDER && fx <= GRID_COLS - BORDER &&
					fy <= GRID_ROWS - BORDER && !square_open_at(fx, fy)) begin
				dirs[n] = dir_t'(d);
				n++;
			end
		end
		return n;
	endfunction

	// Apply one command to the bench copy and return the result it owes
	function automatic rsp_payload_t carve_step(cmd_payload_t item);
		rsp_payload_t r;
		status_t      st;
		dir_t         dirs [4];
		dir_t         pick;
		int           x;
		int           y;
		int           n;
		bit           seen;
		st = ST_ACK;
		seen = 1'b0;
		case (item.command)
			CMD_CLEAR: begin
				foreach (grid_open[row, col]) begin
					grid_open[row][col] = 1'b0;
				end
			end
			CMD_START: begin
				// Any cell goes, even one off the grid or on an even square
				walk_depth = 1;
				walk_x[0] = item.pos_x;
				walk_y[0] = item.pos_y;
			end
			CMD_STEP: begin
				if (walk_depth == 0) begin
					st = ST_FINISHED;
				end else begin
					x = int'(walk_x[walk_depth - 1]);
					y = int'(walk_y[walk_depth - 1]);
					carve_square(x, y);
					n = free_directions(x, y, dirs);
					if (n == 0) begin
						walk_depth--;
						st = (walk_depth == 0) ? ST_FINISHED : ST_BACKTRACKED;
					end else if (walk_depth >= STACK_DEPTH) begin
						// Full stack: top stays opened, nothing else changes
						st = ST_OVERFLOW;
					end else begin
						pick = dirs[int'(item.rand_value) % n];
						carve_square(x + dir_dx(pick), y + dir_dy(pick));
						carve_square(x + 2 * dir_dx(pick), y + 2 * dir_dy(pick));
						walk_x[walk_depth] = 7'(x + 2 * dir_dx(pick));
						walk_y[walk_depth] = 5'(y + 2 * dir_dy(pick));
						walk_depth++;
						st = ST_ADVANCED;
					end
				end
			end
			default: begin
				seen = square_open_at(int'(item.pos_x), int'(item.pos_y));
			end
		endcase
		r.status = st;
		r.top_x = (walk_depth > 0) ? walk_x[walk_depth - 1] : 7'd0;
		r.top_y = (walk_depth > 0) ? walk_y[walk_depth - 1] : 5'd0;
		r.square_open = seen;
		r.stack_depth = 9'(walk_depth);
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Command side
	// ------------------------------------------------------------------

	// Offer one command, wait for its transfer, then log what it owes.
	// A typed expectation replaces the model's, but the model still advances.
	task automatic offer(input cmd_payload_t item, input bit typed,
			input rsp_payload_t typed_rsp, output rsp_payload_t pred);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			cmd_if.valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		cmd_if.valid <= 1'b1;
		cmd_if.data <= item;
		do @(posedge clk); while (!cmd_if.ready);
		pred = carve_step(item);
		expected_results.push_back(typed ? typed_rsp : pred);
		items_sent++;
		// Idle in bursts, leave every fourth stretch and the tail quiet
		idle_on = (items_sent < TOTAL_ITEMS - QUIET_TAIL) && ((items_sent / 150) % 4 != 3);
	endtask

	task automatic issue(input cmd_code_t c, input int x, input int y, input int rnd,
			output rsp_payload_t pred);
		cmd_payload_t item;
		item.command = c;
		item.pos_x = 7'(x);
		item.pos_y = 5'(y);
		item.rand_value = 8'(rnd);
		offer(item, 1'b0, '0, pred);
	endtask

	initial begin : stimulus
		cmd_payload_t item;
		rsp_payload_t typed_rsp;
		rsp_payload_t pred;
		dir_t         dirs [4];
		int           overflows;
		int           steps;
		int           pick;
		cmd_if.valid <= 1'b0;
		cmd_if.data <= '0;
		do @(posedge clk); while (!arst_n);

		// Directed table
		foreach (directed_rows[i]) begin
			item.command = directed_rows[i].cmd;
			item.pos_x = 7'(directed_rows[i].x);
			item.pos_y = 5'(directed_rows[i].y);
			item.rand_value = 8'(directed_rows[i].rnd);
			typed_rsp.status = directed_rows[i].st;
			typed_rsp.top_x = 7'(directed_rows[i].tx);
			typed_rsp.top_y = 5'(directed_rows[i].ty);
			typed_rsp.square_open = 1'(directed_rows[i].sq);
			typed_rsp.stack_depth = 9'(directed_rows[i].depth);
			offer(item, directed_rows[i].typed, typed_rsp, pred);
		end

		// Deep walk: clear the grid at every dead end instead of popping, so
		// the stack only grows until it fills and overflows.
		issue(CMD_START, 3, 3, $urandom_range(0, 255), pred);
		overflows = 0;
		while (overflows < OVERFLOW_TARGET) begin
			if (walk_depth != 0 &&
					free_directions(int'(walk_x[walk_depth - 1]),
						int'(walk_y[walk_depth - 1]), dirs) == 0) begin
				issue(CMD_CLEAR, $urandom_range(0, 127), $urandom_range(0, 31),
					$urandom_range(0, 255), pred);
			end else if ($urandom_range(0, 15) == 0) begin
				issue(CMD_READ, $urandom_range(0, 79), $urandom_range(0, 20),
					$urandom_range(0, 255), pred);
			end else begin
				issue(CMD_STEP, $urandom_range(0, 127), $urandom_range(0, 31),
					$urandom_range(0, 255), pred);
				if (pred.status == ST_OVERFLOW) begin
					overflows++;
				end
			end
		end

		// Random part: mostly whole walks from a legal cell, with reads and
		// the odd clear in between; the rest is unconstrained noise.
		while (items_sent < TOTAL_ITEMS) begin
			if ($urandom_range(0, 9) == 0) begin
				repeat ($urandom_range(1, 4)) begin
					issue(cmd_code_t'($urandom_range(0, 3)), $urandom_range(0, 127),
						$urandom_range(0, 31), $urandom_range(0, 255), pred);
				end
			end else begin
				if ($urandom_range(0, 2) == 0) begin
					issue(CMD_CLEAR, $urandom_range(0, 127), $urandom_range(0, 31),
						$urandom_range(0, 255), pred);
				end
				if ($urandom_range(0, 7) == 0) begin
					issue(CMD_START, $urandom_range(0, 79), $urandom_range(0, 20),
						$urandom_range(0, 255), pred);
				end else begin
					issue(CMD_START, 2 * $urandom_range(1, 38) + 1,
						2 * $urandom_range(1, 7) + 1, $urandom_range(0, 255), pred);
				end
				steps = $urandom_range(5, 150);
				for (int k = 0; k < steps && items_sent < TOTAL_ITEMS; k++) begin
					pick = $urandom_range(0, 19);
					if (pick < 3) begin
						issue(CMD_READ, $urandom_range(0, 79), $urandom_range(0, 20),
							$urandom_range(0, 255), pred);
					end else if (pick == 3) begin
						issue(CMD_READ, $urandom_range(0, 127), $urandom_range(0, 31),
							$urandom_range(0, 255), pred);
					end else if (pick == 4 && $urandom_range(0, 3) == 0) begin
						issue(CMD_CLEAR, $urandom_range(0, 127), $urandom_range(0, 31),
							$urandom_range(0, 255), pred);
					end else begin
						issue(CMD_STEP, $urandom_range(0, 127), $urandom_range(0, 31),
							$urandom_range(0, 255), pred);
					end
				end
			end
		end

		// Drop valid, drain what is owed, then give stray results time to show
		cmd_if.valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (24) @(posedge clk);
		if (fault_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	// ------------------------------------------------------------------
	// Result side: random stalls, plus one long hold that backs the block
	// up into its command channel while commands keep being offered.
	// ------------------------------------------------------------------
	initial begin : result_ready
		rsp_if.ready <= 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin
			if (!hold_done && results_seen >= HOLD_AFTER) begin
				rsp_if.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				rsp_if.ready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end else begin
				rsp_if.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// ------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------
	task automatic note_fault(input string msg);
		fault_count++;
		if (fault_count <= REPORT_LIMIT) begin
			$display("%s", msg);
		end
	endtask

	always @(posedge clk) begin : check_results
		rsp_payload_t want;
		rsp_payload_t got;
		if (arst_n) begin
			if ((cmd_if.valid && cmd_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (rsp_if.valid && rsp_if.ready) begin
				got = rsp_if.data;
				results_seen++;
				if (expected_results.size() == 0) begin
					note_fault($sformatf(
						"result %0d unexpected: st=%0d top=(%0d,%0d) open=%0d depth=%0d",
						results_seen, got.status, got.top_x, got.top_y,
						got.square_open, got.stack_depth));
				end else begin
					want = expected_results.pop_front();
					if (got.status !== want.status || got.top_x !== want.top_x ||
							got.top_y !== want.top_y ||
							got.square_open !== want.square_open ||
							got.stack_depth !== want.stack_depth) begin
						note_fault($sformatf({"result %0d: expected st=%0d top=(%0d,%0d) ",
							"open=%0d depth=%0d, got st=%0d top=(%0d,%0d) open=%0d depth=%0d"},
							results_seen, want.status, want.top_x, want.top_y,
							want.square_open, want.stack_depth, got.status, got.top_x,
							got.top_y, got.square_open, got.stack_depth));
					end
				end
			end
		end
	end

	// End the run if no transfer happens on either channel for too long
	initial begin : watchdog
		do @(posedge clk); while (idle_cycles < WATCHDOG_CYCLES);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
